[hw/rtl/ibfd_pkg.sv]
package ibfd_pkg;

  // Default field widths
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned TIME_BITS_DEF   = 32;

  // Register widths
  localparam int unsigned MAG_W    = 32;
  localparam int unsigned WINDOW_W = 16;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // Result packing: fall_flag, magnitude_sq, over_threshold
  localparam int unsigned OUT_FIELDS_W = 1 + MAG_W + 1;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Register reset values
  localparam logic [MAG_W-1:0]    THRESHOLD_SQ_RST     = 32'd39225169;
  localparam logic [WINDOW_W-1:0] PAIR_WINDOW_RST      = 16'd200;
  localparam logic [WINDOW_W-1:0] RESET_WINDOW_RST     = 16'd700;
  localparam logic [COUNT_W-1:0]  CROSSINGS_NEEDED_RST = 8'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD_SQ     = 2'd0,
    REG_PAIR_WINDOW      = 2'd1,
    REG_RESET_WINDOW     = 2'd2,
    REG_CROSSINGS_NEEDED = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [MAG_W-1:0]    threshold_sq;
    logic [WINDOW_W-1:0] pair_window_ms;
    logic [WINDOW_W-1:0] reset_window_ms;
    logic [COUNT_W-1:0]  crossings_needed;
  } cfg_t;

endpackage

[hw/rtl/ibfd_magnitude.sv]
module ibfd_magnitude #(
  parameter int unsigned SAMPLE_BITS = ibfd_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned TIME_BITS   = ibfd_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_x,
  input  logic signed [SAMPLE_BITS-1:0] in_y,
  input  logic signed [SAMPLE_BITS-1:0] in_z,
  input  logic [TIME_BITS-1:0]          in_now,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ibfd_pkg::MAG_W-1:0]    out_mag,
  output logic [TIME_BITS-1:0]          out_now
);
  import ibfd_pkg::*;

  localparam int unsigned SQ_W  = 2 * SAMPLE_BITS;
  localparam int unsigned SUM_W = SQ_W + 2;
  localparam int unsigned EXT_W = (SUM_W > MAG_W + 1) ? SUM_W : MAG_W + 1;

  // Square stage
  logic                 sq_valid;
  logic [SQ_W-1:0]      sq_x, sq_y, sq_z;
  logic [TIME_BITS-1:0] sq_now;
  logic                 sq_ready;

  logic [SAMPLE_BITS-1:0] abs_x, abs_y, abs_z;
  logic [EXT_W-1:0]       sum;
  logic                   mag_ready;

  // Absolute value; the most negative code maps onto its own bit pattern
  assign abs_x = in_x[SAMPLE_BITS-1] ? (~in_x + 1'b1) : in_x;
  assign abs_y = in_y[SAMPLE_BITS-1] ? (~in_y + 1'b1) : in_y;
  assign abs_z = in_z[SAMPLE_BITS-1] ? (~in_z + 1'b1) : in_z;

  assign mag_ready = !out_valid || out_ready;
  assign sq_ready  = !sq_valid || mag_ready;
  assign in_ready  = sq_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
    end else if (sq_ready) begin
      sq_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sq_ready && in_valid) begin
      sq_x   <= SQ_W'(abs_x) * SQ_W'(abs_x);
      sq_y   <= SQ_W'(abs_y) * SQ_W'(abs_y);
      sq_z   <= SQ_W'(abs_z) * SQ_W'(abs_z);
      sq_now <= in_now;
    end
  end

  // Sum and saturate stage
  assign sum = EXT_W'(sq_x) + EXT_W'(sq_y) + EXT_W'(sq_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mag_ready) begin
      out_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mag_ready && sq_valid) begin
      out_mag <= (sum > EXT_W'({MAG_W{1'b1}})) ? {MAG_W{1'b1}} : sum[MAG_W-1:0];
      out_now <= sq_now;
    end
  end

endmodule

[hw/rtl/ibfd_burst.sv]
module ibfd_burst #(
  parameter int unsigned TIME_BITS = ibfd_pkg::TIME_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ibfd_pkg::cfg_t             cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [ibfd_pkg::MAG_W-1:0] in_mag,
  input  logic [TIME_BITS-1:0]       in_now,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_fall,
  output logic [ibfd_pkg::MAG_W-1:0] out_mag,
  output logic                       out_over
);
  import ibfd_pkg::*;

  logic                 above_flag, above_flag_next;
  logic [COUNT_W-1:0]   crossing_count, crossing_count_next;
  logic [TIME_BITS-1:0] prev_crossing_time, prev_crossing_time_next;
  logic [TIME_BITS-1:0] last_counted_time, last_counted_time_next;

  logic                 adv;
  logic                 over;
  logic                 fall;
  logic [TIME_BITS-1:0] since_counted, since_prev;
  logic [COUNT_W-1:0]   count_base, count_inc;

  assign in_ready = !out_valid || out_ready;
  assign adv      = in_ready && in_valid;

  assign over          = in_mag >= cfg.threshold_sq;
  assign since_counted = in_now - last_counted_time;
  assign since_prev    = in_now - prev_crossing_time;
  assign count_base    = (since_counted >= TIME_BITS'(cfg.reset_window_ms)) ?
                         '0 : crossing_count;
  assign count_inc     = count_base + 1'b1;

  always_comb begin
    above_flag_next         = over;
    crossing_count_next     = count_base;
    prev_crossing_time_next = prev_crossing_time;
    last_counted_time_next  = last_counted_time;
    fall                    = 1'b0;
    if (over && !above_flag) begin
      if (since_prev <= TIME_BITS'(cfg.pair_window_ms)) begin
        if (count_inc >= cfg.crossings_needed) begin
          crossing_count_next = '0;
          fall                = 1'b1;
        end else begin
          crossing_count_next    = count_inc;
          last_counted_time_next = in_now;
        end
      end
      if (!fall) begin
        prev_crossing_time_next = in_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      above_flag         <= 1'b0;
      crossing_count     <= '0;
      prev_crossing_time <= '0;
      last_counted_time  <= '0;
      out_valid          <= 1'b0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (adv) begin
        above_flag         <= above_flag_next;
        crossing_count     <= crossing_count_next;
        prev_crossing_time <= prev_crossing_time_next;
        last_counted_time  <= last_counted_time_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_fall <= fall;
      out_mag  <= in_mag;
      out_over <= over;
    end
  end

  a_fall_needs_over: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_fall |-> out_over)
    else $error("fall flagged on a sample below threshold");

  a_fall_clears_count: assert property (@(posedge clk) disable iff (rst)
    adv && fall |=> crossing_count == '0)
    else $error("count not cleared after a fall");

  a_below_clears_above: assert property (@(posedge clk) disable iff (rst)
    adv && !over |=> !above_flag)
    else $error("above flag held after a sample below threshold");

endmodule

[hw/rtl/impact_burst_fall_detector.sv]
// Impact burst fall detector.
//
// Slave stream (s_*): one accelerometer sample per transaction, three
// signed axis values and a wrapping millisecond time stamp. Master stream
// (m_*): exactly one result per sample, in order: the fall flag, the
// saturated sum of squares and the over-threshold flag.
// Configuration: cfg_wr_en writes cfg_wdata into register cfg_index at the
// rising edge; write only while no sample is in flight.
//
// Pipeline: a sample accepted into the input register passes the square, sum and
// result registers before m_tvalid rises.
// Throughput: one sample per cycle while m_tready is high; each stage holds its
// own valid bit, so bubbles close up and a new sample is taken while a result waits.
// The burst state (above flag, crossing count, two crossing times) is read
// and written in the same cycle at the result register.
//
// Reset (rst, synchronous): clears all stage valid bits and the burst
// state, and loads the register defaults.
// A stall on m_tready holds the result; ready propagates back stage by
// stage, and s_tready drops once every stage holds a sample.
module impact_burst_fall_detector #(
  parameter int unsigned SAMPLE_BITS = ibfd_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned TIME_BITS   = ibfd_pkg::TIME_BITS_DEF,
  localparam int unsigned IN_TDATA_W = ((3 * SAMPLE_BITS + TIME_BITS + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst,
  // accel_x, accel_y, accel_z (SAMPLE_BITS each), now_ms (TIME_BITS), zero pad
  input  logic [IN_TDATA_W-1:0]             s_tdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // fall_flag [0], magnitude_sq [32:1], over_threshold [33], zero pad
  output logic [ibfd_pkg::OUT_TDATA_W-1:0]  m_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic                              cfg_wr_en,
  input  logic [ibfd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ibfd_pkg::CFG_W-1:0]        cfg_wdata
);
  import ibfd_pkg::*;

  localparam int unsigned X_LO = 0;
  localparam int unsigned Y_LO = SAMPLE_BITS;
  localparam int unsigned Z_LO = 2 * SAMPLE_BITS;
  localparam int unsigned T_LO = 3 * SAMPLE_BITS;

  cfg_t cfg;

  // Configuration registers; bits above each register's width drop
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold_sq     <= THRESHOLD_SQ_RST;
      cfg.pair_window_ms   <= PAIR_WINDOW_RST;
      cfg.reset_window_ms  <= RESET_WINDOW_RST;
      cfg.crossings_needed <= CROSSINGS_NEEDED_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_THRESHOLD_SQ:     cfg.threshold_sq     <= cfg_wdata[MAG_W-1:0];
        REG_PAIR_WINDOW:      cfg.pair_window_ms   <= cfg_wdata[WINDOW_W-1:0];
        REG_RESET_WINDOW:     cfg.reset_window_ms  <= cfg_wdata[WINDOW_W-1:0];
        REG_CROSSINGS_NEEDED: cfg.crossings_needed <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  logic                          in_valid;
  logic signed [SAMPLE_BITS-1:0] in_x, in_y, in_z;
  logic [TIME_BITS-1:0]          in_now;
  logic                          mag_in_ready;

  assign s_tready = !in_valid || mag_in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // Capture the fields; padding bits are ignored
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_x   <= s_tdata[X_LO +: SAMPLE_BITS];
      in_y   <= s_tdata[Y_LO +: SAMPLE_BITS];
      in_z   <= s_tdata[Z_LO +: SAMPLE_BITS];
      in_now <= s_tdata[T_LO +: TIME_BITS];
    end
  end

  // Squares and saturated sum
  logic                 mag_valid, mag_ready;
  logic [MAG_W-1:0]     mag;
  logic [TIME_BITS-1:0] mag_now;

  ibfd_magnitude #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_magnitude (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (mag_in_ready),
    .in_x      (in_x),
    .in_y      (in_y),
    .in_z      (in_z),
    .in_now    (in_now),
    .out_valid (mag_valid),
    .out_ready (mag_ready),
    .out_mag   (mag),
    .out_now   (mag_now)
  );

  // Threshold compare, burst tracking and result register
  logic             res_fall, res_over;
  logic [MAG_W-1:0] res_mag;

  ibfd_burst #(
    .TIME_BITS (TIME_BITS)
  ) u_burst (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (mag_valid),
    .in_ready  (mag_ready),
    .in_mag    (mag),
    .in_now    (mag_now),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_fall  (res_fall),
    .out_mag   (res_mag),
    .out_over  (res_over)
  );

  assign m_tdata = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), res_over, res_mag, res_fall};

endmodule
